/* hdl/itda_pkg.sv */
package itda_pkg;

    localparam int VAL_W      = 32;
    localparam int CHAR_W     = 8;
    localparam int BCD_W      = 4;
    localparam int NUM_DIGITS = 10;
    localparam int CNT_W      = $clog2(VAL_W);
    localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // Command broadcast to every digit cell of the chain.
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

endpackage

/* hdl/itda_if.sv */
interface itda_num_if import itda_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface itda_text_if import itda_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

/* hdl/itda_cell.sv */
module itda_cell import itda_pkg::*;
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic             bin_in,
    input  logic [BCD_W-1:0] dig_in,
    output logic             bin_out,
    output logic [BCD_W-1:0] digit
);

    logic [BCD_W-1:0] digit_reg;
    logic [BCD_W-1:0] digit_next;
    logic [BCD_W-1:0] adj;

    // Add three before the shift so that the doubled digit carries at ten.
    assign adj     = (digit_reg >= BCD_W'(5)) ? (digit_reg + BCD_W'(3)) : digit_reg;
    assign bin_out = adj[BCD_W-1];
    assign digit   = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[BCD_W-2:0], bin_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = dig_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

/* hdl/int_to_decimal_ascii_top.sv */
// Channel | Role   | Payload
// num     | sink   | value (signed 32 bits)
// text    | source | char_code (8 bits), last (1 bit)
//
// A request on num is taken only while the converter is idle. The magnitude is
// shifted through a chain of ten BCD digit cells, one bit per cycle. Leading zero
// digits are then dropped at one per cycle, and the sign and digits leave through
// an output register, one character per cycle when text is not stalled.
// Reset (rst_n, asynchronous) clears the control state.
module int_to_decimal_ascii_top import itda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    itda_num_if.sink          num,
    itda_text_if.source       text
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t             state_reg,  state_next;
    logic [VAL_W-1:0]   mag_reg,    mag_next;
    logic               sign_reg,   sign_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [NDIG_W-1:0]  ndig_reg,   ndig_next;
    logic               ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0]  char_reg,   char_next;
    logic               last_reg,   last_next;

    cell_ctrl_t         ctrl;
    logic               bin_c [NUM_DIGITS+1];
    logic [BCD_W-1:0]   dig_c [NUM_DIGITS];
    logic [BCD_W-1:0]   top_digit;
    logic               out_free;
    logic               accept;

    assign bin_c[0]  = mag_reg[VAL_W-1];
    assign top_digit = dig_c[NUM_DIGITS-1];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_DIGITS; gi++)
        begin : g_cell
            logic [BCD_W-1:0] lower;
            if (gi == 0)
            begin : g_first
                assign lower = '0;
            end
            else
            begin : g_rest
                assign lower = dig_c[gi-1];
            end
            itda_cell u_cell (
                .clk     (clk),
                .ctrl    (ctrl),
                .bin_in  (bin_c[gi]),
                .dig_in  (lower),
                .bin_out (bin_c[gi+1]),
                .digit   (dig_c[gi])
            );
        end
    endgenerate

    assign num.ready      = (state_reg == ST_IDLE);
    assign accept         = num.valid && num.ready;
    assign out_free       = !ovalid_reg || text.ready;
    assign text.valid     = ovalid_reg;
    assign text.char_code = char_reg;
    assign text.last      = last_reg;

    always_comb
    begin
        state_next  = state_reg;
        mag_next    = mag_reg;
        sign_next   = sign_reg;
        cnt_next    = cnt_reg;
        ndig_next   = ndig_reg;
        ovalid_next = ovalid_reg && !text.ready;
        char_next   = char_reg;
        last_next   = last_reg;
        ctrl        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sign_next  = num.value[VAL_W-1];
                    mag_next   = num.value[VAL_W-1] ? (~num.value + VAL_W'(1)) : num.value;
                    cnt_next   = '0;
                    ctrl.clear = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.dabble = 1'b1;
                mag_next    = {mag_reg[VAL_W-2:0], 1'b0};
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VAL_W - 1))
                begin
                    ndig_next  = NDIG_W'(NUM_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Zero keeps its last digit so that it prints as a single '0'.
                if ((top_digit == '0) && (ndig_reg != NDIG_W'(1)))
                begin
                    ctrl.shift = 1'b1;
                    ndig_next  = ndig_reg - NDIG_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    if (sign_reg)
                    begin
                        char_next = CHAR_MINUS;
                        last_next = 1'b0;
                        sign_next = 1'b0;
                    end
                    else
                    begin
                        char_next  = CHAR_ZERO + CHAR_W'(top_digit);
                        last_next  = (ndig_reg == NDIG_W'(1));
                        ctrl.shift = 1'b1;
                        ndig_next  = ndig_reg - NDIG_W'(1);
                        if (ndig_reg == NDIG_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        sign_reg <= sign_next;
        cnt_reg  <= cnt_next;
        ndig_reg <= ndig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

/* hdl/itda_checker.sv */
module itda_checker import itda_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              num_valid,
    input logic              num_ready,
    input logic              text_valid,
    input logic              text_ready,
    input logic [CHAR_W-1:0] text_char_code,
    input logic              text_last
);

    // A stalled character must hold until it is taken.
    a_text_hold: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> text_valid && $stable(text_char_code)
                                      && $stable(text_last))
        else $error("text payload changed while stalled");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid |-> (text_char_code == CHAR_MINUS)
                       || ((text_char_code >= CHAR_ZERO) && (text_char_code <= CHAR_NINE)))
        else $error("character outside sign and digits");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && (text_char_code == CHAR_MINUS) |-> !text_last)
        else $error("minus sign flagged as last");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        num_valid && num_ready |=> !num_ready)
        else $error("new number taken during conversion");

endmodule

bind int_to_decimal_ascii_top itda_checker u_itda_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .num_valid      (num.valid),
    .num_ready      (num.ready),
    .text_valid     (text.valid),
    .text_ready     (text.ready),
    .text_char_code (text.char_code),
    .text_last      (text.last)
);
